>>> sv/bda_pkg.sv
// ----------------------------------------------------------------------------
// bda_pkg: shared types and constants for the binary to decimal ASCII block
// Holds the controller state types, field widths and the BCD digit adjust.
// ----------------------------------------------------------------------------
package bda_pkg;

    localparam int IN_W    = 32;
    localparam int CHAR_W  = 6;
    localparam int DIGIT_W = 4;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    typedef enum logic [1:0] {
        CONV_IDLE,
        CONV_RUN,
        CONV_DONE
    } conv_state_t;

    typedef enum logic [1:0] {
        EMIT_IDLE,
        EMIT_SKIP,
        EMIT_SEND
    } emit_state_t;

    // Add three to a BCD digit of five or more before the next shift.
    function automatic logic [DIGIT_W-1:0] bcd_adjust(input logic [DIGIT_W-1:0] d);
        logic [DIGIT_W-1:0] r;
        r = (d >= 4'd5) ? d + 4'd3 : d;
        return r;
    endfunction

endpackage

>>> sv/bda_convert.sv
// ----------------------------------------------------------------------------
// bda_convert: bit-serial binary to BCD converter
// Shifts the value in one bit per cycle, adjusting each BCD digit on the way.
// ----------------------------------------------------------------------------
module bda_convert
    import bda_pkg::*;
#(
    parameter int EFF_W  = 32,
    parameter int DIGITS = 10
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [EFF_W-1:0]          in_value,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [DIGITS*DIGIT_W-1:0] out_bcd
);

    localparam int CW = $clog2(EFF_W + 1);

    conv_state_t               state_reg, state_next;
    logic [EFF_W-1:0]          bin_reg, bin_next;
    logic [DIGITS*DIGIT_W-1:0] bcd_reg, bcd_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic [DIGITS*DIGIT_W-1:0] adjusted;

    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            adjusted[i*DIGIT_W +: DIGIT_W] = bcd_adjust(bcd_reg[i*DIGIT_W +: DIGIT_W]);
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            CONV_IDLE: if (in_valid) state_next = CONV_RUN;
            CONV_RUN:  if (cnt_reg == CW'(1)) state_next = CONV_DONE;
            CONV_DONE: if (out_ready) state_next = CONV_IDLE;
            default:   state_next = CONV_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            CONV_IDLE: begin
                in_ready = 1'b1;
                bin_next = in_value;
                bcd_next = '0;
                cnt_next = CW'(EFF_W);
            end
            CONV_RUN: begin
                bcd_next = {adjusted[DIGITS*DIGIT_W-2:0], bin_reg[EFF_W-1]};
                bin_next = bin_reg << 1;
                cnt_next = cnt_reg - CW'(1);
            end
            CONV_DONE: begin
                out_valid = 1'b1;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign out_bcd = bcd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CONV_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

endmodule

>>> sv/bda_emit.sv
// ----------------------------------------------------------------------------
// bda_emit: BCD digit emitter
// Drops leading zero digits, then sends one ASCII digit per item, MSD first.
// ----------------------------------------------------------------------------
module bda_emit
    import bda_pkg::*;
#(
    parameter int DIGITS = 10
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [DIGITS*DIGIT_W-1:0] in_bcd,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [CHAR_W-1:0]         m_digit_char,
    output logic                      m_last_digit
);

    localparam int LW  = $clog2(DIGITS + 1);
    localparam int TOP = (DIGITS - 1) * DIGIT_W;

    emit_state_t               state_reg, state_next;
    logic [DIGITS*DIGIT_W-1:0] digits_reg, digits_next;
    logic [LW-1:0]             left_reg, left_next;
    logic [DIGIT_W-1:0]        top_digit;
    logic                      last;

    assign top_digit = digits_reg[TOP +: DIGIT_W];
    assign last      = (left_reg == LW'(1));

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            EMIT_IDLE: if (in_valid) state_next = EMIT_SKIP;
            EMIT_SKIP: if (top_digit != '0 || last) state_next = EMIT_SEND;
            EMIT_SEND: if (m_ready && last) state_next = EMIT_IDLE;
            default:   state_next = EMIT_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        digits_next = digits_reg;
        left_next   = left_reg;
        in_ready    = 1'b0;
        m_valid     = 1'b0;
        unique case (state_reg)
            EMIT_IDLE: begin
                in_ready    = 1'b1;
                digits_next = in_bcd;
                left_next   = LW'(DIGITS);
            end
            EMIT_SKIP: begin
                if (top_digit == '0 && !last) begin
                    digits_next = digits_reg << DIGIT_W;
                    left_next   = left_reg - LW'(1);
                end
            end
            EMIT_SEND: begin
                m_valid = 1'b1;
                if (m_ready && !last) begin
                    digits_next = digits_reg << DIGIT_W;
                    left_next   = left_reg - LW'(1);
                end
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign m_digit_char = {{(CHAR_W-DIGIT_W){1'b0}}, top_digit} + ASCII_ZERO;
    assign m_last_digit = last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= EMIT_IDLE;
            left_reg  <= '0;
        end else begin
            state_reg <= state_next;
            left_reg  <= left_next;
        end
        digits_reg <= digits_next;
    end

endmodule

>>> sv/binary_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii: unsigned binary to decimal ASCII text
// Converts one binary value per item into its decimal digits as ASCII.
// ----------------------------------------------------------------------------
// Each accepted item on the s_ channel carries one unsigned value; the block
// answers with one m_ item per decimal digit, most significant first, as the
// ASCII characters '0' to '9', with leading zeros dropped and m_last_digit
// set on the final digit. A value of zero gives the single character '0'.
// Only the low VALUE_WIDTH bits of s_number_in count (at most 32). The
// conversion is a bit-serial shift-and-add-three converter that takes one
// input bit per cycle, then holds its digits until the emitter takes them.
// The emitter then drops each leading zero digit in turn, finds the first
// digit it keeps and sends each digit in turn, waiting on m_ready. The
// converter takes the next item as soon as it has handed its digits to the
// emitter, so conversion of one value overlaps the sending of the previous
// one and a stalled output does not hold the input side back until the
// converter is full.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii
    import bda_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [IN_W-1:0]   s_number_in,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CHAR_W-1:0] m_digit_char,
    output logic              m_last_digit
);

    // Bits that take part, and enough BCD digits to hold their largest value.
    localparam int EFF_W  = (VALUE_WIDTH < IN_W) ? VALUE_WIDTH : IN_W;
    localparam int DIGITS = (EFF_W * 30103) / 100000 + 1;

    logic                      bcd_valid;
    logic                      bcd_ready;
    logic [DIGITS*DIGIT_W-1:0] bcd;

    bda_convert #(
        .EFF_W  (EFF_W),
        .DIGITS (DIGITS)
    ) u_convert (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_value  (s_number_in[EFF_W-1:0]),
        .out_valid (bcd_valid),
        .out_ready (bcd_ready),
        .out_bcd   (bcd)
    );

    bda_emit #(
        .DIGITS (DIGITS)
    ) u_emit (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (bcd_valid),
        .in_ready     (bcd_ready),
        .in_bcd       (bcd),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_digit_char (m_digit_char),
        .m_last_digit (m_last_digit)
    );

endmodule
